// ===== hdl/rwl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and constants for the reader-writer lock arbiter.
// ----------------------------------------------------------------------------
package rwl_pkg;

    localparam int ID_W        = 4;
    localparam int READERS_W   = 5;
    localparam int AGENTS_DEF  = 16;
    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

    localparam logic [READERS_W-1:0] READERS_MAX = 5'd31;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [1:0] {
        REQ_START_READ  = 2'd0,
        REQ_END_READ    = 2'd1,
        REQ_START_WRITE = 2'd2,
        REQ_END_WRITE   = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        OP_START_READ,
        OP_END_READ,
        OP_START_WRITE,
        OP_END_WRITE
    } op_t;

    typedef enum logic [1:0] {
        BK_FETCH,
        BK_EXEC,
        BK_DRAIN
    } bk_state_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] requester_id;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic            granted_kind;
        logic            last_grant;
    } grant_t;

    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] id;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_beat_t;

endpackage

// ===== hdl/rwl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwl_front
// Accepts request beats, decodes them into commands and holds them in a
// short queue until the back end takes them.
// ----------------------------------------------------------------------------
module rwl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rwl_pkg::req_t     req,
    output logic              busy,
    output rwl_pkg::cmd_beat_t cmd_out,
    input  logic              cmd_pop
);
    import rwl_pkg::*;

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] cnt_reg;
    logic [CMD_CNT_W-1:0] cnt_next;
    logic                 push;
    logic                 pop;
    cmd_t                 decoded;

    always_comb
    begin
        decoded.id = req.requester_id;
        unique case (req.req_type)
            REQ_START_READ:  decoded.op = OP_START_READ;
            REQ_END_READ:    decoded.op = OP_END_READ;
            REQ_START_WRITE: decoded.op = OP_START_WRITE;
            REQ_END_WRITE:   decoded.op = OP_END_WRITE;
            default:         decoded.op = OP_END_WRITE;
        endcase
    end

    assign busy = (cnt_reg == CMD_CNT_W'(CMD_DEPTH));
    assign push = start && !busy;
    assign pop  = cmd_pop && (cnt_reg != '0);

    assign cmd_out.valid = (cnt_reg != '0);
    assign cmd_out.cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== hdl/rwl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwl_back
// Lock engine: holds reader count, writer flag and the two wait queues,
// executes one command at a time and issues grant beats.
// ----------------------------------------------------------------------------
module rwl_back #(
    parameter int AGENTS = rwl_pkg::AGENTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rwl_pkg::cmd_beat_t cmd_in,
    output logic               cmd_pop,
    output logic               grant_valid,
    output rwl_pkg::grant_t    grant
);
    import rwl_pkg::*;

    localparam int PTR_W = $clog2(AGENTS);
    localparam int CNT_W = $clog2(AGENTS + 1);

    bk_state_t              state_reg;
    bk_state_t              state_next;
    cmd_t                   cmd_reg;
    logic [READERS_W-1:0]   readers_reg;
    logic [READERS_W-1:0]   readers_next;
    logic                   writer_reg;
    logic                   writer_next;
    logic [PTR_W-1:0]       r_head_reg;
    logic [PTR_W-1:0]       r_head_next;
    logic [PTR_W-1:0]       r_tail_reg;
    logic [PTR_W-1:0]       r_tail_next;
    logic [CNT_W-1:0]       r_cnt_reg;
    logic [CNT_W-1:0]       r_cnt_next;
    logic [PTR_W-1:0]       w_head_reg;
    logic [PTR_W-1:0]       w_head_next;
    logic [PTR_W-1:0]       w_tail_reg;
    logic [PTR_W-1:0]       w_tail_next;
    logic [CNT_W-1:0]       w_cnt_reg;
    logic [CNT_W-1:0]       w_cnt_next;
    logic [ID_W-1:0]        rq_mem [AGENTS];
    logic [ID_W-1:0]        wq_mem [AGENTS];
    logic [ID_W-1:0]        rq_head_reg;
    logic [ID_W-1:0]        wq_head_reg;
    logic                   grant_valid_reg;
    logic                   grant_valid_next;
    grant_t                 grant_reg;
    grant_t                 grant_next;

    logic is_exec;
    logic is_drain;
    logic writer_end;
    logic drain_cond;
    logic rd_fire;
    logic rd_last;
    logic direct_read;
    logic push_r;
    logic end_read_ok;
    logic direct_write;
    logic push_w;
    logic w_pop_er;
    logic w_pop_ew;
    logic w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(AGENTS - 1)) ? '0 : p + 1'b1;
    endfunction

    assign is_exec  = (state_reg == BK_EXEC);
    assign is_drain = (state_reg == BK_DRAIN);
    assign cmd_pop  = (state_reg == BK_FETCH) && cmd_in.valid;

    always_comb
    begin
        writer_end   = is_exec && (cmd_reg.op == OP_END_WRITE) && writer_reg;
        drain_cond   = is_drain || (writer_end && (r_cnt_reg != '0));
        rd_fire      = drain_cond && (readers_reg != READERS_MAX);
        rd_last      = (r_cnt_reg == CNT_W'(1))
                       || (readers_reg == READERS_MAX - 1'b1);
        direct_read  = is_exec && (cmd_reg.op == OP_START_READ) && !writer_reg
                       && (readers_reg != READERS_MAX);
        push_r       = is_exec && (cmd_reg.op == OP_START_READ) && writer_reg
                       && (r_cnt_reg != CNT_W'(AGENTS));
        end_read_ok  = is_exec && (cmd_reg.op == OP_END_READ) && (readers_reg != '0);
        w_pop_er     = end_read_ok && (readers_reg == READERS_W'(1)) && !writer_reg
                       && (w_cnt_reg != '0);
        w_pop_ew     = writer_end && (r_cnt_reg == '0) && (w_cnt_reg != '0);
        w_pop        = w_pop_er || w_pop_ew;
        direct_write = is_exec && (cmd_reg.op == OP_START_WRITE)
                       && (readers_reg == '0) && !writer_reg;
        push_w       = is_exec && (cmd_reg.op == OP_START_WRITE)
                       && ((readers_reg != '0) || writer_reg)
                       && (w_cnt_reg != CNT_W'(AGENTS));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_FETCH:
            begin
                if (cmd_in.valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = (rd_fire && !rd_last) ? BK_DRAIN : BK_FETCH;
            end
            BK_DRAIN:
            begin
                state_next = rd_last ? BK_FETCH : BK_DRAIN;
            end
            default:
            begin
                state_next = BK_FETCH;
            end
        endcase
    end

    always_comb
    begin
        readers_next = readers_reg;
        if (direct_read || rd_fire)
        begin
            readers_next = readers_reg + 1'b1;
        end
        else if (end_read_ok)
        begin
            readers_next = readers_reg - 1'b1;
        end

        writer_next = writer_reg;
        if (direct_write || w_pop)
        begin
            writer_next = 1'b1;
        end
        else if (writer_end)
        begin
            writer_next = 1'b0;
        end

        r_tail_next = push_r  ? ptr_inc(r_tail_reg) : r_tail_reg;
        r_head_next = rd_fire ? ptr_inc(r_head_reg) : r_head_reg;
        r_cnt_next  = r_cnt_reg + CNT_W'(push_r) - CNT_W'(rd_fire);
        w_tail_next = push_w  ? ptr_inc(w_tail_reg) : w_tail_reg;
        w_head_next = w_pop   ? ptr_inc(w_head_reg) : w_head_reg;
        w_cnt_next  = w_cnt_reg + CNT_W'(push_w) - CNT_W'(w_pop);
    end

    always_comb
    begin
        grant_valid_next = direct_read || rd_fire || direct_write || w_pop;
        grant_next       = grant_reg;
        priority if (rd_fire)
        begin
            grant_next.granted_id   = rq_head_reg;
            grant_next.granted_kind = KIND_READ;
            grant_next.last_grant   = rd_last;
        end
        else if (w_pop)
        begin
            grant_next.granted_id   = wq_head_reg;
            grant_next.granted_kind = KIND_WRITE;
            grant_next.last_grant   = 1'b1;
        end
        else if (direct_read)
        begin
            grant_next.granted_id   = cmd_reg.id;
            grant_next.granted_kind = KIND_READ;
            grant_next.last_grant   = 1'b1;
        end
        else if (direct_write)
        begin
            grant_next.granted_id   = cmd_reg.id;
            grant_next.granted_kind = KIND_WRITE;
            grant_next.last_grant   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_FETCH;
            readers_reg     <= '0;
            writer_reg      <= 1'b0;
            r_head_reg      <= '0;
            r_tail_reg      <= '0;
            r_cnt_reg       <= '0;
            w_head_reg      <= '0;
            w_tail_reg      <= '0;
            w_cnt_reg       <= '0;
            grant_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            readers_reg     <= readers_next;
            writer_reg      <= writer_next;
            r_head_reg      <= r_head_next;
            r_tail_reg      <= r_tail_next;
            r_cnt_reg       <= r_cnt_next;
            w_head_reg      <= w_head_next;
            w_tail_reg      <= w_tail_next;
            w_cnt_reg       <= w_cnt_next;
            grant_valid_reg <= grant_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grant_reg <= grant_next;
        if (cmd_pop)
        begin
            cmd_reg <= cmd_in.cmd;
        end
    end

    // head data register follows the next head so it is current every cycle
    always_ff @(posedge clk)
    begin
        if (push_r)
        begin
            rq_mem[r_tail_reg] <= cmd_reg.id;
        end
        rq_head_reg <= rq_mem[r_head_next];
    end

    always_ff @(posedge clk)
    begin
        if (push_w)
        begin
            wq_mem[w_tail_reg] <= cmd_reg.id;
        end
        wq_head_reg <= wq_mem[w_head_next];
    end

    assign grant_valid = grant_valid_reg;
    assign grant       = grant_reg;

`ifndef SYNTHESIS
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(writer_reg && (readers_reg != '0)))
        else $error("writer and readers hold the lock together");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DRAIN) |-> (r_cnt_reg != '0))
        else $error("drain with empty read queue");

    a_grant_src: assert property (@(posedge clk) disable iff (!rst_n)
        grant_valid_next |-> (state_reg != BK_FETCH))
        else $error("grant issued while fetching");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (r_cnt_reg <= CNT_W'(AGENTS)) && (w_cnt_reg <= CNT_W'(AGENTS)))
        else $error("wait queue count overflow");

    a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == BK_EXEC))
        else $error("command taken without execution");
`endif

endmodule

// ===== hdl/reader_writer_lock_arbiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reader_writer_lock_arbiter
// Reader-writer lock manager with reader preference.
//
// Request channel: a beat (req.req_type, req.requester_id) is taken on a
// rising edge with start high and busy low. The front end decodes it into a
// two-entry command queue; busy is high while that queue is full.
// Grant channel: each grant is on grant for one cycle with grant_valid high;
// grant.last_grant marks the final grant of a request. Requests that only
// queue or are ignored produce no beat. The receiver cannot stall.
// A first grant passes the command queue, the engine's command register and
// the grant register. The lock engine fetches and executes one request at a
// time; an end write releasing waiting readers drains them after execute,
// one read-queue pop per cycle through the queue's registered read port.
// Reset clears reader count, writer flag and both wait queues; queue
// storage itself needs no clearing.
// ----------------------------------------------------------------------------
module reader_writer_lock_arbiter #(
    parameter int AGENTS = rwl_pkg::AGENTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rwl_pkg::req_t   req,
    output logic            busy,
    output logic            grant_valid,
    output rwl_pkg::grant_t grant
);
    import rwl_pkg::*;

    cmd_beat_t cmd_beat;
    logic      cmd_pop;

    rwl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .cmd_out (cmd_beat),
        .cmd_pop (cmd_pop)
    );

    rwl_back #(
        .AGENTS (AGENTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_in      (cmd_beat),
        .cmd_pop     (cmd_pop),
        .grant_valid (grant_valid),
        .grant       (grant)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for reader_writer_lock_arbiter. Lock requests are sent through
// the start/busy handshake. A scoreboard keeps its own copy of the lock
// state: reader count, writer flag and both wait queues. For every request
// it predicts the grants, in order, with the flag on the last one. Each
// grant beat is then compared field by field with the oldest prediction.
// A short directed sequence covers the ignored requests, queueing and
// release. Random bursts follow: noise, reader storms up to the reader
// limit, mixed traffic, and a queue fill that overflows both wait queues
// and releases a full read queue at once. The sender idles at several
// rates.
// ----------------------------------------------------------------------------
module tb_top;
    import rwl_pkg::*;

    localparam int QUEUE_DEPTH    = AGENTS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 420;
    localparam int MAX_REPORTS    = 10;

    class lock_scoreboard;
        logic [READERS_W-1:0] readers;
        bit                   writer_holds;
        logic [ID_W-1:0]      read_waiters[$];
        logic [ID_W-1:0]      write_waiters[$];
        grant_t               pending_grants[$];
        int                   errors;

        function new();
            readers      = '0;
            writer_holds = 1'b0;
            errors       = 0;
        endfunction

        function void push_grant(logic [ID_W-1:0] id, logic kind);
            grant_t g;
            g.granted_id   = id;
            g.granted_kind = kind;
            g.last_grant   = 1'b0;
            pending_grants.push_back(g);
        endfunction

        function void note_request(req_t r);
            int first;
            first = pending_grants.size();
            case (req_code_t'(r.req_type))
                REQ_START_READ:
                    if (writer_holds)
                    begin
                        if (read_waiters.size() < QUEUE_DEPTH)
                            read_waiters.push_back(r.requester_id);
                    end
                    else if (readers < READERS_MAX)
                    begin
                        readers++;
                        push_grant(r.requester_id, KIND_READ);
                    end
                REQ_END_READ:
                    if (readers != 0)
                    begin
                        readers--;
                        if (readers == 0 && !writer_holds && write_waiters.size() > 0)
                        begin
                            writer_holds = 1'b1;
                            push_grant(write_waiters.pop_front(), KIND_WRITE);
                        end
                    end
                REQ_START_WRITE:
                    if (readers != 0 || writer_holds)
                    begin
                        if (write_waiters.size() < QUEUE_DEPTH)
                            write_waiters.push_back(r.requester_id);
                    end
                    else
                    begin
                        writer_holds = 1'b1;
                        push_grant(r.requester_id, KIND_WRITE);
                    end
                default:
                    if (writer_holds)
                    begin
                        writer_holds = 1'b0;
                        if (read_waiters.size() > 0)
                        begin
                            while (read_waiters.size() > 0 && readers < READERS_MAX)
                            begin
                                readers++;
                                push_grant(read_waiters.pop_front(), KIND_READ);
                            end
                        end
                        else if (write_waiters.size() > 0)
                        begin
                            writer_holds = 1'b1;
                            push_grant(write_waiters.pop_front(), KIND_WRITE);
                        end
                    end
            endcase
            if (pending_grants.size() > first)
                pending_grants[pending_grants.size() - 1].last_grant = 1'b1;
        endfunction

        function void check_grant(grant_t g);
            grant_t e;
            if (pending_grants.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected grant beat: id=%0d kind=%0d last=%0d",
                             g.granted_id, g.granted_kind, g.last_grant);
                return;
            end
            e = pending_grants.pop_front();
            if (g.granted_id !== e.granted_id || g.granted_kind !== e.granted_kind ||
                g.last_grant !== e.last_grant)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"grant mismatch: expected id=%0d kind=%0d last=%0d,",
                              " got id=%0d kind=%0d last=%0d"},
                             e.granted_id, e.granted_kind, e.last_grant,
                             g.granted_id, g.granted_kind, g.last_grant);
            end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   start;
    req_t   req;
    logic   busy;
    logic   grant_valid;
    grant_t grant;

    lock_scoreboard sb;
    int             idle_pct;
    int             applied;
    int             quiet_cycles = 0;
    int             phase_idle[4] = '{0, 71, 26, 0};

    reader_writer_lock_arbiter u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req),
        .busy        (busy),
        .grant_valid (grant_valid),
        .grant       (grant)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (grant_valid)
                sb.check_grant(grant);
            if (start && !busy)
                sb.note_request(req);
            if (grant_valid || (start && !busy))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'($urandom_range(15));
    endfunction

    function automatic req_code_t pick_kind(int w0, int w1, int w2, int w3);
        int roll;
        roll = $urandom_range(w0 + w1 + w2 + w3 - 1);
        if (roll < w0)
            return REQ_START_READ;
        if (roll < w0 + w1)
            return REQ_END_READ;
        if (roll < w0 + w1 + w2)
            return REQ_START_WRITE;
        return REQ_END_WRITE;
    endfunction

    // called and returns at a falling edge
    task automatic send_req(input req_code_t kind, input logic [ID_W-1:0] id);
        req_t r;
        r.req_type     = kind;
        r.requester_id = id;
        applied++;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic send_state_aware();
        if (sb.writer_holds)
            send_req(pick_kind(40, 5, 30, 25), rand_id());
        else if (sb.readers != 0)
            send_req(pick_kind(30, 45, 20, 5), rand_id());
        else
            send_req(pick_kind(40, 5, 40, 15), rand_id());
    endtask

    task automatic run_burst();
        int mode;
        mode = $urandom_range(9);
        case (mode)
            0, 1: repeat (10) send_req(pick_kind(1, 1, 1, 1), rand_id());
            2, 3: repeat (60) send_req(pick_kind(75, 20, 4, 1), rand_id());
            4, 5: repeat (30) send_req(pick_kind(40, 5, 35, 20), rand_id());
            6, 7: repeat (30) send_state_aware();
            default:
            begin
                // writer holds, both queues overflow, then one release
                while (sb.readers != 0)
                    send_req(REQ_END_READ, rand_id());
                if (!sb.writer_holds)
                    send_req(REQ_START_WRITE, rand_id());
                repeat (QUEUE_DEPTH + 1) send_req(REQ_START_READ, rand_id());
                repeat (QUEUE_DEPTH + 1) send_req(REQ_START_WRITE, rand_id());
                send_req(REQ_END_WRITE, rand_id());
            end
        endcase
    endtask

    initial
    begin
        sb       = new();
        start    = 1'b0;
        req      = '0;
        rst_n    = 1'b0;
        idle_pct = 0;
        applied  = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_req(REQ_END_READ, 4'd0);
        send_req(REQ_END_WRITE, 4'd15);
        send_req(REQ_START_READ, 4'd0);
        send_req(REQ_START_READ, 4'd15);
        send_req(REQ_START_WRITE, 4'd9);
        send_req(REQ_START_WRITE, 4'd6);
        send_req(REQ_END_READ, 4'd3);
        send_req(REQ_END_READ, 4'd12);
        send_req(REQ_START_READ, 4'd5);
        send_req(REQ_START_READ, 4'd10);
        send_req(REQ_START_WRITE, 4'd1);
        send_req(REQ_END_WRITE, 4'd14);
        send_req(REQ_END_READ, 4'd0);
        send_req(REQ_END_READ, 4'd0);
        send_req(REQ_END_WRITE, 4'd2);
        send_req(REQ_END_WRITE, 4'd7);
        send_req(REQ_END_WRITE, 4'd8);
        send_req(REQ_START_WRITE, 4'd15);
        send_req(REQ_START_READ, 4'd7);
        send_req(REQ_END_WRITE, 4'd11);
        send_req(REQ_END_READ, 4'd4);

        applied = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = phase_idle[phase];
            while (applied < (phase + 1) * RANDOM_ITEMS / 4)
                run_burst();
        end
        start <= 1'b0;

        while (sb.pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending_grants.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rwl_pkg.sv
hdl/rwl_front.sv
hdl/rwl_back.sv
hdl/reader_writer_lock_arbiter.sv
verif/tb_top.sv
